// File: rtl/atrp_pkg.sv
package atrp_pkg;

  // Input sample and intermediate widths (set by the 16-bit raw fields)
  localparam int SAMPLE_W    = 16;
  localparam int ABSN_W      = SAMPLE_W + 1;   // |-32768| needs 17 bits
  localparam int SQ_W        = 2 * SAMPLE_W - 1;
  localparam int SUM_W       = SQ_W + 1;
  localparam int ROOT_W      = SUM_W;          // sqrt of a 64-bit radicand
  localparam int SQRT_STAGES = ROOT_W;         // one root bit per cell
  localparam int REM_W       = ROOT_W + 4;
  localparam int MAG_FRAC    = 16;

  // CORDIC datapath
  localparam int DEG_FRAC    = 24;             // angle accumulator fraction bits
  localparam int ROM_SIZE    = 24;
  localparam int XY_W        = 36;
  localparam int ACC_W       = 33;

  localparam int CORDIC_STAGES_DEF   = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;

  localparam logic [63:0] RAD2DEG_Q24 = 64'd961263669;

  typedef struct packed {
    logic neg;
    logic num_zero;
    logic mag_zero;
  } atrp_side_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  rad;
    logic [ABSN_W-1:0] absn;
    atrp_side_t        side;
  } atrp_sqrt_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ACC_W-1:0] acc;
    atrp_side_t              side;
  } atrp_cord_t;

  // atan(2^-idx) in degrees, Q24. Evaluated at elaboration only: the radian
  // value is an alternating series in Q60, each term found by long division.
  function automatic logic [31:0] atan_q24(input int idx);
    logic [63:0] rad;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] prod;
    int          k;
    int          b;
    int          e;
    int          d;
    if (idx == 0) begin
      return 32'd45 << DEG_FRAC;
    end
    rad = '0;
    for (k = 0; k < 32; k++) begin
      if (idx * (2 * k + 1) <= 60) begin
        e   = 60 - idx * (2 * k + 1);
        d   = 2 * k + 1;
        rem = '0;
        quo = '0;
        for (b = 63; b >= 0; b--) begin
          rem = {rem[62:0], (b == e)};
          quo = {quo[62:0], 1'b0};
          if (rem >= 64'(d)) begin
            rem    = rem - 64'(d);
            quo[0] = 1'b1;
          end
        end
        if (k % 2 == 1) begin
          rad = rad - quo;
        end else begin
          rad = rad + quo;
        end
      end
    end
    prod = (rad >> 28) * RAD2DEG_Q24 + (64'd1 << 31);
    return prod[63:32];
  endfunction

endpackage

// File: rtl/atrp_sqrt_cell.sv
module atrp_sqrt_cell
  import atrp_pkg::*;
(
  input  logic       clk,
  input  atrp_sqrt_t cell_in,
  output atrp_sqrt_t cell_out
);

  atrp_sqrt_t       cell_r;
  atrp_sqrt_t       cell_nxt;
  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;

  // bring down the next two radicand bits, try a one in the next root bit
  always_comb begin
    rem_sh   = {cell_in.rem[REM_W-3:0], cell_in.rad[SUM_W-1 -: 2]};
    trial    = {2'b00, cell_in.root, 2'b01};
    cell_nxt = cell_in;
    cell_nxt.rad = {cell_in.rad[SUM_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      cell_nxt.rem  = rem_sh - trial;
      cell_nxt.root = {cell_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      cell_nxt.rem  = rem_sh;
      cell_nxt.root = {cell_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;

endmodule

// File: rtl/atrp_cordic_cell.sv
module atrp_cordic_cell
  import atrp_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  logic       clk,
  input  atrp_cord_t cell_in,
  output atrp_cord_t cell_out
);

  localparam logic signed [ACC_W-1:0] ROM_VAL = $signed({1'b0, atan_q24(STAGE)});

  atrp_cord_t             cell_r;
  atrp_cord_t             cell_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  // rotate toward the x axis; y sign picks the direction
  always_comb begin
    xs       = $signed(cell_in.x) >>> STAGE;
    ys       = $signed(cell_in.y) >>> STAGE;
    cell_nxt = cell_in;
    if (!cell_in.y[XY_W-1]) begin
      cell_nxt.x   = $signed(cell_in.x) + ys;
      cell_nxt.y   = $signed(cell_in.y) - xs;
      cell_nxt.acc = $signed(cell_in.acc) + ROM_VAL;
    end else begin
      cell_nxt.x   = $signed(cell_in.x) - ys;
      cell_nxt.y   = $signed(cell_in.y) + xs;
      cell_nxt.acc = $signed(cell_in.acc) - ROM_VAL;
    end
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;

endmodule

// File: rtl/atrp_lane.sv
module atrp_lane
  import atrp_pkg::*;
#(
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic [SQ_W-1:0]                   sq_a,
  input  logic [SQ_W-1:0]                   sq_b,
  input  logic [ABSN_W-1:0]                 absn,
  input  logic                              num_neg,
  input  logic                              num_zero,
  output logic signed [ANGLE_FRAC_BITS+7:0] angle
);

  localparam int OUT_W  = ANGLE_FRAC_BITS + 8;
  localparam int RND_SH = DEG_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(90) << DEG_FRAC;
  localparam logic [ACC_W-1:0]        HALF    = ACC_W'(1) << (RND_SH - 1);
  localparam logic signed [OUT_W-1:0] LIMIT   = OUT_W'(90) << ANGLE_FRAC_BITS;

  atrp_sqrt_t sq_pipe [SQRT_STAGES+1];
  atrp_cord_t cd_pipe [CORDIC_STAGES+1];

  atrp_sqrt_t              entry_r;
  atrp_sqrt_t              entry_nxt;
  logic [SUM_W-1:0]        sumsq;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_c;
  logic [ACC_W-1:0]        rnd;
  logic signed [OUT_W-1:0] mag;
  logic signed [OUT_W-1:0] angle_r;
  logic signed [OUT_W-1:0] angle_nxt;
  atrp_side_t              side_end;

  // sum of squares, special-case flags
  always_comb begin
    sumsq                  = SUM_W'(sq_a) + SUM_W'(sq_b);
    entry_nxt.rem          = '0;
    entry_nxt.root         = '0;
    entry_nxt.rad          = sumsq;
    entry_nxt.absn         = absn;
    entry_nxt.side.neg      = num_neg;
    entry_nxt.side.num_zero = num_zero;
    entry_nxt.side.mag_zero = (sumsq == '0);
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign sq_pipe[0] = entry_r;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    atrp_sqrt_cell u_cell (
      .clk      (clk),
      .cell_in  (sq_pipe[j]),
      .cell_out (sq_pipe[j+1])
    );
  end

  // magnitude carries 16 fraction bits; scale numerator to match
  assign cd_pipe[0].x    = $signed({{(XY_W-ROOT_W){1'b0}}, sq_pipe[SQRT_STAGES].root});
  assign cd_pipe[0].y    = $signed({{(XY_W-ABSN_W-MAG_FRAC){1'b0}}, sq_pipe[SQRT_STAGES].absn,
                                    {MAG_FRAC{1'b0}}});
  assign cd_pipe[0].acc  = '0;
  assign cd_pipe[0].side = sq_pipe[SQRT_STAGES].side;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    atrp_cordic_cell #(
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .cell_in  (cd_pipe[i]),
      .cell_out (cd_pipe[i+1])
    );
  end

  // clamp to [0, 90], round half up, apply sign; a zero numerator gives 0, a zero magnitude +/-90
  always_comb begin
    acc      = cd_pipe[CORDIC_STAGES].acc;
    side_end = cd_pipe[CORDIC_STAGES].side;
    if (acc[ACC_W-1]) begin
      acc_c = '0;
    end else if (acc > ACC_MAX) begin
      acc_c = ACC_MAX;
    end else begin
      acc_c = acc;
    end
    rnd = acc_c + HALF;
    mag = $signed(rnd[RND_SH +: OUT_W]);
    if (side_end.num_zero) begin
      angle_nxt = '0;
    end else if (side_end.mag_zero) begin
      angle_nxt = side_end.neg ? -LIMIT : LIMIT;
    end else begin
      angle_nxt = side_end.neg ? -mag : mag;
    end
  end

  always_ff @(posedge clk) begin
    angle_r <= angle_nxt;
  end

  assign angle = angle_r;

endmodule

// File: rtl/accel_tilt_roll_pitch.sv
// Channel  | Ports                                   | Handshake
// -------- | --------------------------------------- | ----------------------------------
// input    | in_accel_x, in_accel_y, in_accel_z      | beat taken when start && !busy
// result   | out_roll_deg, out_pitch_deg             | beat shown one cycle with out_valid
//
// One sample per cycle, back to back. The pipeline is a square stage, then in two
// identical lanes for roll and pitch a sum stage, 32 square-root cells, one CORDIC
// cell per stage and a rounding stage.
// Reset is synchronous and active low; busy is high only while rst_n is low and
// any beat in flight is dropped. Results cannot be held off by the receiver.
module accel_tilt_roll_pitch
  import atrp_pkg::*;
#(
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [SAMPLE_W-1:0]        in_accel_x,
  input  logic signed [SAMPLE_W-1:0]        in_accel_y,
  input  logic signed [SAMPLE_W-1:0]        in_accel_z,
  output logic                              out_valid,
  output logic signed [ANGLE_FRAC_BITS+7:0] out_roll_deg,
  output logic signed [ANGLE_FRAC_BITS+7:0] out_pitch_deg
);

  localparam int LAT   = 3 + SQRT_STAGES + CORDIC_STAGES;
  localparam int OUT_W = ANGLE_FRAC_BITS + 8;
  localparam logic signed [OUT_W-1:0] LIMIT = OUT_W'(90) << ANGLE_FRAC_BITS;

  logic [LAT-1:0]    vld_r;
  logic [LAT-1:0]    vld_nxt;
  logic              accept;

  logic [SQ_W-1:0]   sqx_r;
  logic [SQ_W-1:0]   sqy_r;
  logic [SQ_W-1:0]   sqz_r;
  logic [ABSN_W-1:0] roll_absn_r;
  logic [ABSN_W-1:0] pitch_absn_r;
  logic              roll_neg_r;
  logic              roll_zero_r;
  logic              pitch_neg_r;
  logic              pitch_zero_r;

  logic signed [2*SAMPLE_W-1:0] prod_x;
  logic signed [2*SAMPLE_W-1:0] prod_y;
  logic signed [2*SAMPLE_W-1:0] prod_z;
  logic [ABSN_W-1:0]            abs_x;
  logic [ABSN_W-1:0]            abs_y;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[LAT-1];

  always_comb begin
    prod_x = in_accel_x * in_accel_x;
    prod_y = in_accel_y * in_accel_y;
    prod_z = in_accel_z * in_accel_z;
    abs_x  = in_accel_x[SAMPLE_W-1] ? ABSN_W'(-$signed({in_accel_x[SAMPLE_W-1], in_accel_x}))
                                    : {1'b0, in_accel_x};
    abs_y  = in_accel_y[SAMPLE_W-1] ? ABSN_W'(-$signed({in_accel_y[SAMPLE_W-1], in_accel_y}))
                                    : {1'b0, in_accel_y};
  end

  // roll numerator is -x: negative when x is positive
  always_ff @(posedge clk) begin
    sqx_r        <= prod_x[SQ_W-1:0];
    sqy_r        <= prod_y[SQ_W-1:0];
    sqz_r        <= prod_z[SQ_W-1:0];
    roll_absn_r  <= abs_x;
    pitch_absn_r <= abs_y;
    roll_zero_r  <= (in_accel_x == '0);
    roll_neg_r   <= ~in_accel_x[SAMPLE_W-1] & (in_accel_x != '0);
    pitch_zero_r <= (in_accel_y == '0);
    pitch_neg_r  <= in_accel_y[SAMPLE_W-1];
  end

  atrp_lane #(
    .CORDIC_STAGES   (CORDIC_STAGES),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_roll (
    .clk      (clk),
    .sq_a     (sqy_r),
    .sq_b     (sqz_r),
    .absn     (roll_absn_r),
    .num_neg  (roll_neg_r),
    .num_zero (roll_zero_r),
    .angle    (out_roll_deg)
  );

  atrp_lane #(
    .CORDIC_STAGES   (CORDIC_STAGES),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_pitch (
    .clk      (clk),
    .sq_a     (sqx_r),
    .sq_b     (sqz_r),
    .absn     (pitch_absn_r),
    .num_neg  (pitch_neg_r),
    .num_zero (pitch_zero_r),
    .angle    (out_pitch_deg)
  );

  // every accepted beat raises out_valid when it leaves the pipeline
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted beat did not produce a result after the pipeline latency");

  a_roll_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_roll_deg) <= LIMIT && $signed(out_roll_deg) >= -LIMIT))
    else $error("roll result outside +/-90 degrees");

  a_pitch_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_pitch_deg) <= LIMIT && $signed(out_pitch_deg) >= -LIMIT))
    else $error("pitch result outside +/-90 degrees");

  a_reset_flush : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe seen right after reset");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import atrp_pkg::*;

  localparam int TILT_STAGES = CORDIC_STAGES_DEF;
  localparam int FRAC_BITS   = ANGLE_FRAC_BITS_DEF;
  localparam int OUT_W       = FRAC_BITS + 8;
  localparam int RIGHT_ANGLE = 90 << FRAC_BITS;
  localparam int TAIL_CYCLES = 35 + TILT_STAGES + 12;
  localparam int RANDOM_ITEMS = 400;
  localparam int N_DIRECTED  = 25;

  typedef logic signed [SAMPLE_W-1:0] axis_t;
  typedef logic signed [OUT_W-1:0]    angle_t;

  typedef struct {
    axis_t x;
    axis_t y;
    axis_t z;
  } accel_sample_t;

  typedef struct {
    accel_sample_t s;
    angle_t        roll;
    angle_t        pitch;
  } tilt_pair_t;

  typedef struct {
    axis_t  x;
    axis_t  y;
    axis_t  z;
    bit     fixed;
    angle_t roll;
    angle_t pitch;
  } directed_row_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  axis_t in_accel_x = '0;
  axis_t in_accel_y = '0;
  axis_t in_accel_z = '0;
  logic  out_valid;
  angle_t out_roll_deg;
  angle_t out_pitch_deg;

  longint     atan_deg_q24 [ROM_SIZE];
  tilt_pair_t tilt_expected [$];
  int         mismatch_count = 0;
  int         pairs_checked = 0;
  int         rails_seen = 0;

  // fixed rows carry the angle that can be read off directly: zero numerators,
  // zero magnitudes (straight up or down the sensed axis) and the -32768 corner
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{16'sd0,      16'sd0,      16'sd0,      1'b1, 15'sd0,      15'sd0},
    '{16'sd0,      16'sd0,      16'sd16384,  1'b1, 15'sd0,      15'sd0},
    '{16'sd0,      16'sd0,      -16'sd32768, 1'b1, 15'sd0,      15'sd0},
    '{16'sd16384,  16'sd0,      16'sd0,      1'b1, -15'sd11520, 15'sd0},
    '{-16'sd16384, 16'sd0,      16'sd0,      1'b1, 15'sd11520,  15'sd0},
    '{-16'sd32768, 16'sd0,      16'sd0,      1'b1, 15'sd11520,  15'sd0},
    '{16'sd32767,  16'sd0,      16'sd0,      1'b1, -15'sd11520, 15'sd0},
    '{16'sd0,      16'sd32767,  16'sd0,      1'b1, 15'sd0,      15'sd11520},
    '{16'sd0,      -16'sd32768, 16'sd0,      1'b1, 15'sd0,      -15'sd11520},
    '{16'sd1,      16'sd0,      16'sd0,      1'b1, -15'sd11520, 15'sd0},
    '{16'sd0,      -16'sd1,     16'sd0,      1'b1, 15'sd0,      -15'sd11520},
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 15'sd0,      15'sd0},
    '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, 15'sd0,      15'sd0},
    '{-16'sd32768, 16'sd32767,  16'sd0,      1'b0, 15'sd0,      15'sd0},
    '{16'sd32767,  -16'sd32768, -16'sd32768, 1'b0, 15'sd0,      15'sd0},
    '{16'sd0,      16'sd0,      16'sd1,      1'b0, 15'sd0,      15'sd0},
    '{16'sd100,    -16'sd200,   16'sd16384,  1'b0, 15'sd0,      15'sd0},
    '{-16'sd8192,  16'sd4096,   16'sd14000,  1'b0, 15'sd0,      15'sd0},
    '{16'sd1,      16'sd1,      16'sd1,      1'b0, 15'sd0,      15'sd0},
    '{-16'sd1,     -16'sd1,     -16'sd1,     1'b0, 15'sd0,      15'sd0},
    '{16'sd16384,  16'sd16384,  16'sd0,      1'b0, 15'sd0,      15'sd0},
    '{16'sd11585,  16'sd0,      16'sd11585,  1'b0, 15'sd0,      15'sd0},
    '{16'sd0,      16'sd11585,  -16'sd11585, 1'b0, 15'sd0,      15'sd0},
    '{-16'sd32768, -16'sd32768, 16'sd0,      1'b0, 15'sd0,      15'sd0},
    '{16'sd5,      -16'sd3,     16'sd32767,  1'b0, 15'sd0,      15'sd0}
  };

  accel_tilt_roll_pitch u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_accel_x   (in_accel_x),
    .in_accel_y   (in_accel_y),
    .in_accel_z   (in_accel_z),
    .out_valid    (out_valid),
    .out_roll_deg (out_roll_deg),
    .out_pitch_deg(out_pitch_deg)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // atan(2^-i) in degrees Q24, from the Q60 radian series
  function automatic longint atan_entry(input int i);
    logic [63:0] rad;
    logic [63:0] term;
    int          e;
    if (i == 0) return longint'(45) << DEG_FRAC;
    rad = '0;
    for (int k = 0; 60 - i * (2 * k + 1) >= 0; k++) begin
      e    = 60 - i * (2 * k + 1);
      term = (64'd1 << e) / 64'(2 * k + 1);
      if (k % 2 == 1) rad = rad - term;
      else rad = rad + term;
    end
    return longint'(((rad >> 28) * 64'd961263669 + (64'd1 << 31)) >> 32);
  endfunction

  function automatic logic [63:0] isqrt_u64(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitpos;
    root   = '0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v    = v - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  // atan2(num, sqrt(a*a + b*b)) in degrees, FRAC_BITS fraction bits
  function automatic angle_t tilt_angle_q(input longint num, input longint a,
                                          input longint b);
    logic [63:0] sumsq;
    logic [63:0] mag;
    longint      absn;
    longint      cx;
    longint      cy;
    longint      acc;
    longint      xs;
    longint      ys;
    longint      r;
    sumsq = 64'(a * a + b * b);
    mag   = isqrt_u64(sumsq << 32);
    absn  = (num < 0) ? -num : num;
    if (absn == 0) return '0;
    if (mag == 0) return (num < 0) ? angle_t'(-RIGHT_ANGLE) : angle_t'(RIGHT_ANGLE);
    cx  = longint'(mag);
    cy  = absn << 16;
    acc = 0;
    for (int i = 0; i < TILT_STAGES && i < ROM_SIZE; i++) begin
      xs = cx >>> i;
      ys = cy >>> i;
      if (cy >= 0) begin
        cx  = cx + ys;
        cy  = cy - xs;
        acc = acc + atan_deg_q24[i];
      end else begin
        cx  = cx - ys;
        cy  = cy + xs;
        acc = acc - atan_deg_q24[i];
      end
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(90) << DEG_FRAC)) acc = longint'(90) << DEG_FRAC;
    r = (acc + (longint'(1) << (DEG_FRAC - FRAC_BITS - 1))) >> (DEG_FRAC - FRAC_BITS);
    if (r > RIGHT_ANGLE) r = RIGHT_ANGLE;
    return (num < 0) ? angle_t'(-r) : angle_t'(r);
  endfunction

  function automatic tilt_pair_t predict_tilt(input accel_sample_t s);
    tilt_pair_t p;
    p.s     = s;
    p.roll  = tilt_angle_q(-longint'(s.x), longint'(s.y), longint'(s.z));
    p.pitch = tilt_angle_q(longint'(s.y), longint'(s.x), longint'(s.z));
    return p;
  endfunction

  function automatic axis_t random_axis();
    axis_t v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = -16'sd32768;
          1: v = 16'sd32767;
          2: v = 16'sd0;
          3: v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      1: v = axis_t'(int'($urandom_range(0, 16)) - 8);
      2, 3, 4: v = axis_t'($urandom);
      // up to about one g either way on a +/-2 g range
      default: v = axis_t'(int'($urandom_range(0, 33000)) - 16500);
    endcase
    return v;
  endfunction

  function automatic accel_sample_t random_sample();
    accel_sample_t s;
    s.x = random_axis();
    s.y = random_axis();
    s.z = random_axis();
    // lay the sensor flat along one axis now and then to hit zero magnitudes and zero numerators
    case ($urandom_range(0, 11))
      0: begin s.y = '0; s.z = '0; end
      1: begin s.x = '0; s.z = '0; end
      2: begin s.x = '0; s.y = '0; end
      default: ;
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  // hold start and the fields until the beat is taken
  task automatic send_sample(input tilt_pair_t want);
    start      <= 1'b1;
    in_accel_x <= want.s.x;
    in_accel_y <= want.s.y;
    in_accel_z <= want.s.z;
    @(posedge clk);
    while (busy) @(posedge clk);
    tilt_expected.push_back(want);
  endtask

  always @(posedge clk) begin
    tilt_pair_t want;
    if (rst_n && out_valid) begin
      if (tilt_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result roll=%0d pitch=%0d",
                                  out_roll_deg, out_pitch_deg));
      end else begin
        want = tilt_expected.pop_front();
        pairs_checked++;
        if (want.roll == RIGHT_ANGLE || want.roll == -RIGHT_ANGLE) rails_seen++;
        if (out_roll_deg !== want.roll)
          report_mismatch($sformatf("roll x=%0d y=%0d z=%0d: got %0d, want %0d",
                                    want.s.x, want.s.y, want.s.z, out_roll_deg, want.roll));
        if (out_pitch_deg !== want.pitch)
          report_mismatch($sformatf("pitch x=%0d y=%0d z=%0d: got %0d, want %0d",
                                    want.s.x, want.s.y, want.s.z, out_pitch_deg, want.pitch));
      end
    end
  end

  initial begin
    tilt_pair_t    want;
    accel_sample_t s;
    int            sent_random;
    int            burst_len;
    int            gap;
    for (int i = 0; i < ROM_SIZE; i++) atan_deg_q24[i] = atan_entry(i);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      s.x = directed_rows[i].x;
      s.y = directed_rows[i].y;
      s.z = directed_rows[i].z;
      if (directed_rows[i].fixed) begin
        want.s     = s;
        want.roll  = directed_rows[i].roll;
        want.pitch = directed_rows[i].pitch;
      end else begin
        want = predict_tilt(s);
      end
      send_sample(want);
    end

    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 24);
      for (int b = 0; b < burst_len && sent_random < RANDOM_ITEMS; b++) begin
        send_sample(predict_tilt(random_sample()));
        sent_random++;
      end
      // some bursts run straight into the next one
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (tilt_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d samples (%0d table rows, %0d random) in bursts with gaps;",
             N_DIRECTED + sent_random, N_DIRECTED, sent_random);
    $display("checked %0d roll/pitch pairs, %0d with roll pinned at +/-90 degrees.",
             pairs_checked, rails_seen);
    if (mismatch_count == 0) begin
      $display("accel_tilt_roll_pitch: match");
    end else begin
      $display("accel_tilt_roll_pitch: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", tilt_expected.size());
    $display("accel_tilt_roll_pitch: mismatch");
    $finish;
  end

endmodule
